// ===== src/psw_pkg.sv =====
// Package with constants, payload types and state codes of the priority scheduler.
package psw_pkg;

    localparam int MAX_PROCS = 32;
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int KEY_W = 8 + IDX_W;

    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        final_item;
    } req_t;

    typedef struct packed {
        logic [5:0]  proc_id;
        logic [7:0]  prio_out;
        logic [15:0] burst_out;
        logic [20:0] wait_time;
        logic [20:0] turnaround;
        logic [24:0] wait_total;
        logic [25:0] turnaround_total;
        logic [5:0]  proc_count;
        logic        dropped;
        logic        last_out;
    } rslt_t;

    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== src/psw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/priority_schedule_wait_times.sv =====
// Top level of the nonpreemptive priority scheduler with wait and turnaround times.
//
// A request is taken at a rising edge with start high and busy low. Each request
// stores one process (burst, priority) in the entry RAM, numbered 1 upward in
// arrival order; requests beyond the table capacity are dropped and flagged. A
// request with final_item set closes the batch and raises busy.
// The block then emits every stored process in ascending priority order, equal
// priorities in arrival order. Each result is found by one full scan of the
// loaded entries in the RAM, one read per cycle, for the smallest (priority,
// number) key above the previously emitted one; the RAM has a single read port.
// Requests can be loaded back to back while busy is low.
// Each result is shown for one cycle with strobe high and cannot be stalled.
// The last result carries last_out and the batch totals; busy then falls and
// the table is empty for the next batch.
// Reset clears the count, the overflow flag and the controller; the RAM
// contents are not cleared, since only entries of the current batch are read.
module priority_schedule_wait_times (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  psw_pkg::req_t   req,
    output logic            strobe,
    output psw_pkg::rslt_t  rslt
);

    psw_pkg::state_t             state_reg, state_next;
    logic [psw_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [psw_pkg::CNT_W-1:0]   issue_reg, issue_next;
    logic [psw_pkg::CNT_W-1:0]   emitted_reg, emitted_next;
    logic                        pend_reg;
    logic [psw_pkg::IDX_W-1:0]   pend_idx_reg;
    logic                        first_reg, first_next;
    logic [psw_pkg::KEY_W-1:0]   prev_key_reg, prev_key_next;
    logic                        best_valid_reg, best_valid_next;
    logic [psw_pkg::KEY_W-1:0]   best_key_reg, best_key_next;
    psw_pkg::entry_t             best_entry_reg, best_entry_next;
    logic [20:0]                 wait_reg, wait_next;
    logic [24:0]                 wsum_reg, wsum_next;
    logic [25:0]                 tsum_reg, tsum_next;
    logic                        strobe_reg, strobe_next;
    psw_pkg::rslt_t              rslt_reg, rslt_next;

    logic                        wr_en;
    logic                        rd_en;
    logic [psw_pkg::IDX_W-1:0]   rd_addr;
    psw_pkg::entry_t             wr_entry;
    psw_pkg::entry_t             rd_entry;
    logic [psw_pkg::KEY_W-1:0]   cand_key;
    logic                        take;
    logic [20:0]                 ta;
    logic                        last;

    assign wr_entry = '{burst: req.burst, prio: req.prio};
    assign rd_addr  = issue_reg[psw_pkg::IDX_W-1:0];

    psw_ram #(
        .WIDTH (psw_pkg::ENTRY_W),
        .DEPTH (psw_pkg::MAX_PROCS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[psw_pkg::IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psw_pkg::ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            issue_reg      <= '0;
            emitted_reg    <= '0;
            pend_reg       <= 1'b0;
            first_reg      <= 1'b1;
            best_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            issue_reg      <= issue_next;
            emitted_reg    <= emitted_next;
            pend_reg       <= rd_en;
            first_reg      <= first_next;
            best_valid_reg <= best_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= rd_addr;
        prev_key_reg   <= prev_key_next;
        best_key_reg   <= best_key_next;
        best_entry_reg <= best_entry_next;
        wait_reg       <= wait_next;
        wsum_reg       <= wsum_next;
        tsum_reg       <= tsum_next;
        rslt_reg       <= rslt_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        issue_next      = issue_reg;
        emitted_next    = emitted_reg;
        first_next      = first_reg;
        prev_key_next   = prev_key_reg;
        best_valid_next = best_valid_reg;
        best_key_next   = best_key_reg;
        best_entry_next = best_entry_reg;
        wait_next       = wait_reg;
        wsum_next       = wsum_reg;
        tsum_next       = tsum_reg;
        strobe_next     = 1'b0;
        rslt_next       = rslt_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        cand_key        = {rd_entry.prio, pend_idx_reg};
        take            = pend_reg && (first_reg || cand_key > prev_key_reg)
                          && (!best_valid_reg || cand_key < best_key_reg);
        ta              = '0;
        last            = 1'b0;

        unique case (state_reg)
            psw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < psw_pkg::CNT_W'(psw_pkg::MAX_PROCS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (req.final_item)
                    begin
                        state_next      = psw_pkg::ST_SCAN;
                        issue_next      = '0;
                        emitted_next    = '0;
                        first_next      = 1'b1;
                        best_valid_next = 1'b0;
                        wait_next       = '0;
                        wsum_next       = '0;
                        tsum_next       = '0;
                    end
                end
            end
            psw_pkg::ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (take)
                begin
                    best_valid_next = 1'b1;
                    best_key_next   = cand_key;
                    best_entry_next = rd_entry;
                end
                if (pend_reg && pend_idx_reg == psw_pkg::IDX_W'(count_reg - 1'b1))
                begin
                    ta   = wait_reg + 21'(best_entry_next.burst);
                    last = (emitted_reg + 1'b1) == count_reg;
                    wsum_next = wsum_reg + 25'(wait_reg);
                    tsum_next = tsum_reg + 26'(ta);
                    rslt_next.proc_id    = 6'(best_key_next[psw_pkg::IDX_W-1:0]) + 6'd1;
                    rslt_next.prio_out   = best_entry_next.prio;
                    rslt_next.burst_out  = best_entry_next.burst;
                    rslt_next.wait_time  = wait_reg;
                    rslt_next.turnaround = ta;
                    rslt_next.wait_total       = last ? wsum_next : '0;
                    rslt_next.turnaround_total = last ? tsum_next : '0;
                    rslt_next.proc_count = 6'(count_reg);
                    rslt_next.dropped    = ovf_reg;
                    rslt_next.last_out   = last;
                    strobe_next     = 1'b1;
                    wait_next       = ta;
                    emitted_next    = emitted_reg + 1'b1;
                    issue_next      = '0;
                    first_next      = 1'b0;
                    prev_key_next   = best_key_next;
                    best_valid_next = 1'b0;
                    if (last)
                    begin
                        state_next = psw_pkg::ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = psw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != psw_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign rslt   = rslt_reg;

`ifndef SYNTHESIS
    a_final_raises_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.final_item |=> busy)
        else $error("final request did not start the drain");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && rslt.last_out |-> !busy && count_reg == '0)
        else $error("batch not closed after last result");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> issue_reg < count_reg)
        else $error("read beyond loaded entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= psw_pkg::CNT_W'(psw_pkg::MAX_PROCS))
        else $error("entry count above capacity");
`endif

endmodule

// ===== bench/priority_schedule_wait_times_tb.sv =====
// Self-checking testbench of the priority scheduler: directed table, an overflow batch, then random batches.
module priority_schedule_wait_times_tb;

    localparam int N_DIRECTED = 12;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    psw_pkg::req_t   req;
    logic            strobe;
    psw_pkg::rslt_t  rslt;

    psw_pkg::entry_t  sched_table[psw_pkg::MAX_PROCS];
    int               sched_count;
    bit               sched_over;
    psw_pkg::rslt_t   sched_queue[$];
    int               mismatches;
    int               sent;

    typedef struct {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        final_item;
        bit          typed;
        logic [20:0] wait_exp;
        logic        dropped_exp;
    } row_t;

    row_t dir_rows[N_DIRECTED];

    priority_schedule_wait_times dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .strobe(strobe), .rslt(rslt)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("priority_schedule_wait_times_tb: FAIL");
        $finish;
    end

    task automatic schedule_request(input psw_pkg::req_t r);
        int order[psw_pkg::MAX_PROCS];
        int n;
        int j;
        int k;
        logic [63:0] w;
        logic [63:0] ta;
        logic [63:0] ws;
        logic [63:0] ts;
        psw_pkg::rslt_t o;
        begin
            if (sched_count < psw_pkg::MAX_PROCS)
            begin
                sched_table[sched_count].burst = r.burst;
                sched_table[sched_count].prio = r.prio;
                sched_count++;
            end
            else
                sched_over = 1'b1;
            if (r.final_item)
            begin
                n = sched_count;
                for (int i = 0; i < n; i++)
                begin
                    j = i;
                    while (j > 0 && sched_table[order[j-1]].prio > sched_table[i].prio)
                    begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = i;
                end
                w = 0; ws = 0; ts = 0;
                for (int i = 0; i < n; i++)
                begin
                    k = order[i];
                    ta = w + sched_table[k].burst;
                    ws += w;
                    ts += ta;
                    o = '0;
                    o.proc_id = 6'(k + 1);
                    o.prio_out = sched_table[k].prio;
                    o.burst_out = sched_table[k].burst;
                    o.wait_time = w[20:0];
                    o.turnaround = ta[20:0];
                    o.proc_count = 6'(n);
                    o.dropped = sched_over;
                    if (i == n - 1)
                    begin
                        o.wait_total = ws[24:0];
                        o.turnaround_total = ts[25:0];
                        o.last_out = 1'b1;
                    end
                    sched_queue.push_back(o);
                    w = ta;
                end
                sched_count = 0;
                sched_over = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (sched_queue.size() == 0)
                report_mismatch("unexpected result", rslt.proc_id, 0);
            else
            begin
                psw_pkg::rslt_t e;
                e = sched_queue.pop_front();
                if (rslt.proc_id !== e.proc_id)
                    report_mismatch("proc_id", rslt.proc_id, e.proc_id);
                if (rslt.prio_out !== e.prio_out)
                    report_mismatch("prio_out", rslt.prio_out, e.prio_out);
                if (rslt.burst_out !== e.burst_out)
                    report_mismatch("burst_out", rslt.burst_out, e.burst_out);
                if (rslt.wait_time !== e.wait_time)
                    report_mismatch("wait_time", rslt.wait_time, e.wait_time);
                if (rslt.turnaround !== e.turnaround)
                    report_mismatch("turnaround", rslt.turnaround, e.turnaround);
                if (rslt.wait_total !== e.wait_total)
                    report_mismatch("wait_total", rslt.wait_total, e.wait_total);
                if (rslt.turnaround_total !== e.turnaround_total)
                    report_mismatch("turnaround_total", rslt.turnaround_total,
                                    e.turnaround_total);
                if (rslt.proc_count !== e.proc_count)
                    report_mismatch("proc_count", rslt.proc_count, e.proc_count);
                if (rslt.dropped !== e.dropped)
                    report_mismatch("dropped", rslt.dropped, e.dropped);
                if (rslt.last_out !== e.last_out)
                    report_mismatch("last_out", rslt.last_out, e.last_out);
            end
        end
    end

    task automatic send_request(input psw_pkg::req_t r, input bit gaps);
        int gap;
        begin
            if (gaps && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 14);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            req <= r;
            @(posedge clk);
            while (busy) @(posedge clk);
            schedule_request(r);
            sent++;
        end
    endtask

    task automatic drain_results();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (sched_queue.size() != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        psw_pkg::req_t r;
        int len;
        int wait_cycles;
        mismatches = 0;
        sent = 0;
        sched_count = 0;
        sched_over = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        dir_rows[0] = '{16'hFFFF, 8'd0, 1'b1, 1'b1, 21'd0, 1'b0};
        dir_rows[1] = '{16'd0, 8'hFF, 1'b1, 1'b1, 21'd0, 1'b0};
        dir_rows[2] = '{16'd5, 8'd9, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[3] = '{16'd7, 8'd3, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[4] = '{16'd1, 8'd9, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[5] = '{16'hFFFF, 8'd3, 1'b1, 1'b0, 21'd0, 1'b0};
        dir_rows[6] = '{16'hAAAA, 8'h55, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[7] = '{16'h5555, 8'hAA, 1'b1, 1'b0, 21'd0, 1'b0};
        dir_rows[8] = '{16'hFFFF, 8'hFF, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[9] = '{16'hFFFF, 8'hFF, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[10] = '{16'hFFFF, 8'd0, 1'b0, 1'b0, 21'd0, 1'b0};
        dir_rows[11] = '{16'h1234, 8'd0, 1'b1, 1'b0, 21'd0, 1'b0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            r.burst = dir_rows[i].burst;
            r.prio = dir_rows[i].prio;
            r.final_item = dir_rows[i].final_item;
            send_request(r, 1'b0);
            if (dir_rows[i].typed)
                if (sched_queue.size() == 0
                    || sched_queue[$].wait_time !== dir_rows[i].wait_exp
                    || sched_queue[$].dropped !== dir_rows[i].dropped_exp)
                    report_mismatch("directed row", i, i);
        end
        // Overflow batch: 35 requests, the dropped final one still closes it.
        for (int i = 0; i < 35; i++)
        begin
            r.burst = $urandom;
            r.prio = $urandom_range(0, 3);
            r.final_item = (i == 34);
            send_request(r, 1'b0);
        end

        while (sent < 210)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                              : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                r.burst = ($urandom_range(0, 4) == 0) ? 16'hFFFF : $urandom;
                r.prio = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
                r.final_item = (i == len - 1);
                send_request(r, sent < 180);
            end
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end

        start <= 1'b0;
        wait_cycles = 0;
        while (sched_queue.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && sched_queue.size() == 0)
            $display("priority_schedule_wait_times_tb: PASS");
        else
            $display("priority_schedule_wait_times_tb: FAIL");
        $finish;
    end
endmodule

// ===== priority_schedule_wait_times.f =====
src/psw_pkg.sv
src/psw_ram.sv
src/priority_schedule_wait_times.sv
bench/priority_schedule_wait_times_tb.sv
